// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the line breaker RTL; included by glb_dp.
// Clocked on clk, disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked check.
`define GLB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define GLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/glb_pkg.sv =====
// Shared types and codes for the greedy line breaker.
// Used by glb_ctrl, glb_dp and the top level.
package glb_pkg;

  localparam logic [23:0] W24 = 24'hFFFFFF;

  // character classes
  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_SPACE = 3'd1;
  localparam logic [2:0] CLS_LF    = 3'd3;
  localparam logic [2:0] CLS_CR    = 3'd4;

  // wrap modes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_WORD  = 2'd1;
  localparam logic [1:0] MODE_CHAR  = 2'd2;
  localparam logic [1:0] MODE_EMERG = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_WRAP_MODE  = 3'd0;
  localparam logic [2:0] REG_MAX_WIDTH  = 3'd1;
  localparam logic [2:0] REG_MAX_LINES  = 3'd2;
  localparam logic [2:0] REG_LINE_PITCH = 3'd3;
  localparam logic [2:0] REG_ASCENT     = 3'd4;

  // glyph store read address select
  localparam logic [2:0] RS_I   = 3'd0;
  localparam logic [2:0] RS_JM1 = 3'd1;
  localparam logic [2:0] RS_J   = 3'd2;
  localparam logic [2:0] RS_KM1 = 3'd3;
  localparam logic [2:0] RS_IP1 = 3'd4;

  // line parameter sources
  localparam logic [1:0] E_MAIN  = 2'd0;
  localparam logic [1:0] E_FINAL = 2'd1;
  localparam logic [1:0] E_WORD  = 2'd2;
  localparam logic [1:0] E_EMPTY = 2'd3;

  typedef struct packed {
    logic       load;
    logic       begin_txt;
    logic [2:0] rsel;
    logic       emit;
    logic [1:0] esel;
    logic       step_rd;
    logic       step_cur;
    logic       bk_init;
    logic       bk_dec;
    logic       tr_acc;
    logic       store;
    logic       nl_next;
    logic       nl_skip;
    logic       restart;
    logic       wd_start;
    logic       sk_inc;
    logic       flush;
  } glb_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       i_lt_n;
    logic       ip1_lt_n;
    logic       j_gt_ls;
    logic       k_gt_lo;
    logic       ls_lt_n;
    logic       lines_lt_lim;
    logic       ovf;
    logic       mode_char;
    logic [2:0] cls;
  } glb_stat_t;

endpackage

// ===== rtl/core/glb_ctrl.sv =====
// Sequencer for the line breaking pass.
// Depends on glb_pkg; drives glb_dp through glb_cmd_t.
module glb_ctrl import glb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      last_glyph,
  input  glb_stat_t stat,
  output glb_cmd_t  cmd,
  output logic      busy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK0   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_EV     = 4'd3;
  localparam logic [3:0] S_BK_RD  = 4'd4;
  localparam logic [3:0] S_BK_EV  = 4'd5;
  localparam logic [3:0] S_BRK_RD = 4'd6;
  localparam logic [3:0] S_BRK_EV = 4'd7;
  localparam logic [3:0] S_TR_RD  = 4'd8;
  localparam logic [3:0] S_TR_EV  = 4'd9;
  localparam logic [3:0] S_STORE  = 4'd10;
  localparam logic [3:0] S_POST   = 4'd11;
  localparam logic [3:0] S_CR_EV  = 4'd12;
  localparam logic [3:0] S_SK_RD  = 4'd13;
  localparam logic [3:0] S_SK_EV  = 4'd14;
  localparam logic [3:0] S_FLUSH  = 4'd15;

  // what follows a line once it is stored
  localparam logic [1:0] C_END = 2'd0;
  localparam logic [1:0] C_NL  = 2'd1;
  localparam logic [1:0] C_CH  = 2'd2;
  localparam logic [1:0] C_WD  = 2'd3;

  logic [3:0] state, state_next;
  logic [1:0] ctx, ctx_next;
  logic       cr, cr_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctx   <= C_END;
      cr    <= 1'b0;
    end else begin
      state <= state_next;
      ctx   <= ctx_next;
      cr    <= cr_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rsel   = RS_I;
    state_next = state;
    ctx_next   = ctx;
    cr_next    = cr;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_glyph) begin
            cmd.begin_txt = 1'b1;
            state_next = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        if (stat.empty) begin
          cmd.emit = 1'b1;
          cmd.esel = E_EMPTY;
          ctx_next = C_END;
          state_next = S_TR_RD;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (stat.i_lt_n) begin
          cmd.rsel = RS_I;
          state_next = S_EV;
        end else if (stat.ls_lt_n && stat.lines_lt_lim) begin
          cmd.emit = 1'b1;
          cmd.esel = E_FINAL;
          ctx_next = C_END;
          state_next = S_TR_RD;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_EV: begin
        if (stat.cls == CLS_LF || stat.cls == CLS_CR) begin
          cmd.emit = 1'b1;
          cmd.esel = E_MAIN;
          ctx_next = C_NL;
          cr_next  = (stat.cls == CLS_CR);
          state_next = S_TR_RD;
        end else if (stat.ovf && stat.mode_char) begin
          cmd.emit = 1'b1;
          cmd.esel = E_MAIN;
          ctx_next = C_CH;
          state_next = S_TR_RD;
        end else if (stat.ovf) begin
          cmd.bk_init = 1'b1;
          state_next = S_BK_RD;
        end else begin
          cmd.step_rd = 1'b1;
          state_next = S_RD;
        end
      end
      S_BK_RD: begin
        if (stat.j_gt_ls) begin
          cmd.rsel = RS_JM1;
          state_next = S_BK_EV;
        end else begin
          // no boundary: the line keeps growing
          cmd.step_cur = 1'b1;
          state_next = S_RD;
        end
      end
      S_BK_EV: begin
        if (stat.cls == CLS_SPACE) begin
          state_next = S_BRK_RD;
        end else begin
          cmd.bk_dec = 1'b1;
          state_next = S_BK_RD;
        end
      end
      S_BRK_RD: begin
        cmd.rsel = RS_J;
        state_next = S_BRK_EV;
      end
      S_BRK_EV: begin
        cmd.emit = 1'b1;
        cmd.esel = E_WORD;
        ctx_next = C_WD;
        state_next = S_TR_RD;
      end
      S_TR_RD: begin
        if (stat.k_gt_lo) begin
          cmd.rsel = RS_KM1;
          state_next = S_TR_EV;
        end else begin
          state_next = S_STORE;
        end
      end
      S_TR_EV: begin
        if (stat.cls != CLS_OTHER) begin
          cmd.tr_acc = 1'b1;
          state_next = S_TR_RD;
        end else begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_next = S_POST;
      end
      S_POST: begin
        if (ctx == C_END || !stat.lines_lt_lim) begin
          state_next = S_FLUSH;
        end else begin
          unique case (ctx)
            C_NL: begin
              if (cr && stat.ip1_lt_n) begin
                cmd.rsel = RS_IP1;
                state_next = S_CR_EV;
              end else begin
                cmd.nl_next = 1'b1;
                state_next = S_RD;
              end
            end
            C_CH: begin
              cmd.restart = 1'b1;
              state_next = S_RD;
            end
            C_WD: begin
              cmd.wd_start = 1'b1;
              state_next = S_SK_RD;
            end
            default: state_next = S_FLUSH;
          endcase
        end
      end
      S_CR_EV: begin
        // CR LF ends one line only
        cmd.nl_next = 1'b1;
        cmd.nl_skip = (stat.cls == CLS_LF);
        state_next = S_RD;
      end
      S_SK_RD: begin
        if (stat.i_lt_n) begin
          cmd.rsel = RS_I;
          state_next = S_SK_EV;
        end else begin
          cmd.restart = 1'b1;
          state_next = S_RD;
        end
      end
      S_SK_EV: begin
        if (stat.cls == CLS_SPACE) begin
          cmd.sk_inc = 1'b1;
          state_next = S_SK_RD;
        end else begin
          cmd.restart = 1'b1;
          state_next = S_RD;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/glb_dp.sv =====
// Datapath: glyph store, counters, width sums, pending line and result registers.
// Depends on glb_pkg and assert_macros.svh; commanded by glb_ctrl.
`include "assert_macros.svh"
module glb_dp import glb_pkg::*; #(
  parameter int MAX_GLYPHS   = 256,
  parameter int MAX_LINE_OUT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  glb_cmd_t    cmd,
  output glb_stat_t   stat,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic [15:0] advance,
  input  logic [2:0]  char_class,
  input  logic [15:0] cluster,
  input  logic        glyph_valid,
  input  logic [15:0] text_length,
  output logic        result_valid,
  output logic [8:0]  line_start,
  output logic [15:0] line_end_char,
  output logic [23:0] line_width,
  output logic [23:0] trimmed_width,
  output logic [21:0] baseline_y,
  output logic        last_line,
  output logic [23:0] total_width,
  output logic [23:0] total_width_ws,
  output logic [21:0] total_height,
  output logic [6:0]  line_count
);

  localparam int AW = $clog2(MAX_GLYPHS);
  localparam int CW = AW + 1;
  localparam int SW = (AW + 17 > 25) ? AW + 17 : 25;

  // configuration
  logic [1:0]  wrap_mode;
  logic [23:0] max_width;
  logic [6:0]  max_lines;
  logic [15:0] line_pitch;
  logic [15:0] ascent;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_mode  <= MODE_WORD;
      max_width  <= 24'd0;
      max_lines  <= 7'd64;
      line_pitch <= 16'd1024;
      ascent     <= 16'd819;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WRAP_MODE:  wrap_mode  <= cfg_data[1:0];
        REG_MAX_WIDTH:  max_width  <= cfg_data;
        REG_MAX_LINES:  max_lines  <= cfg_data[6:0];
        REG_LINE_PITCH: line_pitch <= cfg_data[15:0];
        REG_ASCENT:     ascent     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // glyph store: advance, class, cluster
  logic [34:0] mem [MAX_GLYPHS];
  logic [34:0] rdata;
  logic [AW-1:0] raddr;

  logic [CW-1:0] n, i, ls, j, k, e_lo, pend_lo;
  logic [15:0]   text_len;
  logic [SW-1:0] raw, wacc, tsub;
  logic [15:0]   cur_adv;
  logic [6:0]    lines_done;
  logic [23:0]   widest_t, widest_f;
  logic [15:0]   e_endc, pend_endc;
  logic [23:0]   e_w, pend_w, pend_t;
  logic [21:0]   pend_base;
  logic          pend_v;

  always_comb begin
    unique case (cmd.rsel)
      RS_I:    raddr = i[AW-1:0];
      RS_JM1:  raddr = AW'(j - CW'(1));
      RS_J:    raddr = j[AW-1:0];
      RS_KM1:  raddr = AW'(k - CW'(1));
      RS_IP1:  raddr = AW'(i + CW'(1));
      default: raddr = i[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load && glyph_valid && n < CW'(MAX_GLYPHS))
      mem[n[AW-1:0]] <= {cluster, char_class, advance};
    rdata <= mem[raddr];
  end

  logic [15:0] rd_adv, rd_clu;
  logic [2:0]  rd_cls;
  assign rd_adv = rdata[15:0];
  assign rd_clu = rdata[34:19];
  // glyphs outside the text, or with a class code above CR, count as other
  assign rd_cls = (rd_clu >= text_len || rdata[18:16] > CLS_CR) ? CLS_OTHER : rdata[18:16];

  function automatic logic [23:0] sat(input logic [SW-1:0] v);
    sat = (v > SW'(W24)) ? W24 : v[23:0];
  endfunction

  logic [23:0] pen_x;
  logic [6:0]  limit;
  logic [22:0] mul;
  logic [23:0] trim_v;
  assign pen_x = sat(raw);
  assign limit = (max_lines == 7'd0 || max_lines > 7'(MAX_LINE_OUT)) ? 7'(MAX_LINE_OUT)
                                                                   : max_lines;
  assign mul = 23'(lines_done) * 23'(line_pitch);
  assign trim_v = (SW'(e_w) > tsub) ? e_w - tsub[23:0] : 24'd0;

  always_comb begin
    stat.empty        = (n == '0) || (text_len == 16'd0);
    stat.i_lt_n       = i < n;
    stat.ip1_lt_n     = (i + CW'(1)) < n;
    stat.j_gt_ls      = j > ls;
    stat.k_gt_lo      = k > e_lo;
    stat.ls_lt_n      = ls < n;
    stat.lines_lt_lim = lines_done < limit;
    stat.ovf          = wrap_mode != MODE_NONE && max_width != 24'd0 && pen_x != 24'd0 &&
                        (25'(pen_x) + 25'(rd_adv)) > 25'(max_width);
    stat.mode_char    = wrap_mode >= MODE_CHAR;
    stat.cls          = rd_cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      text_len <= 16'd0;
      i <= '0;
      ls <= '0;
      raw <= '0;
      lines_done <= 7'd0;
      widest_t <= 24'd0;
      widest_f <= 24'd0;
      pend_v <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // a store releases the previous pending line; flush releases the last one
      result_valid <= cmd.flush || (cmd.store && pend_v);
      if (cmd.load && glyph_valid && n < CW'(MAX_GLYPHS))
        n <= n + CW'(1);
      if (cmd.begin_txt) begin
        text_len <= text_length;
        i <= '0;
        ls <= '0;
        raw <= '0;
        lines_done <= 7'd0;
        widest_t <= 24'd0;
        widest_f <= 24'd0;
        pend_v <= 1'b0;
      end
      if (cmd.step_rd) begin
        raw <= raw + SW'(rd_adv);
        i <= i + CW'(1);
      end
      if (cmd.step_cur) begin
        raw <= raw + SW'(cur_adv);
        i <= i + CW'(1);
      end
      if (cmd.nl_next) begin
        i  <= i + (cmd.nl_skip ? CW'(2) : CW'(1));
        ls <= i + (cmd.nl_skip ? CW'(2) : CW'(1));
        raw <= '0;
      end
      if (cmd.restart) begin
        ls <= i;
        raw <= '0;
      end
      if (cmd.wd_start)
        i <= j;
      if (cmd.sk_inc)
        i <= i + CW'(1);
      if (cmd.store) begin
        if (SW'(trim_v) > SW'(widest_t)) widest_t <= trim_v;
        if (e_w > widest_f) widest_f <= e_w;
        lines_done <= lines_done + 7'd1;
        pend_v <= 1'b1;
        if (pend_v) begin
          line_start     <= 9'(pend_lo);
          line_end_char  <= pend_endc;
          line_width     <= pend_w;
          trimmed_width  <= pend_t;
          baseline_y     <= pend_base;
          last_line      <= 1'b0;
          total_width    <= 24'd0;
          total_width_ws <= 24'd0;
          total_height   <= 22'd0;
          line_count     <= 7'd0;
        end
      end
      if (cmd.flush) begin
        n <= '0;
        line_start     <= 9'(pend_lo);
        line_end_char  <= pend_endc;
        line_width     <= pend_w;
        trimmed_width  <= pend_t;
        baseline_y     <= pend_base;
        last_line      <= 1'b1;
        total_width    <= widest_t;
        total_width_ws <= widest_f;
        total_height   <= 22'(mul);
        line_count     <= lines_done;
      end
    end
  end

  // payload-only registers
  always_ff @(posedge clk) begin
    if (cmd.bk_init) begin
      cur_adv <= rd_adv;
      j <= i;
      wacc <= raw;
    end
    if (cmd.bk_dec) begin
      wacc <= wacc - SW'(rd_adv);
      j <= j - CW'(1);
    end
    if (cmd.emit) begin
      tsub <= '0;
      unique case (cmd.esel)
        E_MAIN: begin
          e_lo <= ls; k <= i; e_endc <= rd_clu; e_w <= pen_x;
        end
        E_FINAL: begin
          e_lo <= ls; k <= n; e_endc <= text_len; e_w <= pen_x;
        end
        E_WORD: begin
          e_lo <= ls; k <= j; e_endc <= rd_clu; e_w <= sat(wacc);
        end
        E_EMPTY: begin
          e_lo <= '0; k <= '0; e_endc <= 16'd0; e_w <= 24'd0;
        end
        default: ;
      endcase
    end
    if (cmd.tr_acc) begin
      tsub <= tsub + SW'(rd_adv);
      k <= k - CW'(1);
    end
    if (cmd.store) begin
      pend_lo   <= e_lo;
      pend_endc <= e_endc;
      pend_w    <= e_w;
      pend_t    <= trim_v;
      pend_base <= 22'(24'(mul) + 24'(ascent));
    end
  end

  `GLB_ASSERT(a_lines_cap, lines_done <= 7'(MAX_LINE_OUT), "line count past limit")
  `GLB_ASSERT(a_store_cap, n <= CW'(MAX_GLYPHS), "glyph count past store depth")
  `GLB_ASSERT_NEXT(a_last_once, result_valid && last_line, !result_valid,
                   "result after last line")
  `GLB_ASSERT(a_trim_le_width, !result_valid || trimmed_width <= line_width,
              "trimmed width above line width")

endmodule

// ===== rtl/core/greedy_line_breaker.sv =====
// Greedy line breaker: glyphs load one per cycle while idle; the item with last_glyph
// starts the pass, and busy drops in the cycle the last line is strobed.
// Pass: glyphs are read then evaluated; a word-mode overflow scans back to a space,
// trailing whitespace is trimmed, a CR checks for LF, a word break skips spaces.
// Lines leave one line late; an empty text strobes one line. No receiver stall.
// Synchronous active-high reset clears control state and loads register defaults.
module greedy_line_breaker import glb_pkg::*; #(
  parameter int MAX_GLYPHS   = 256,
  parameter int MAX_LINE_OUT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic [15:0] advance,
  input  logic [2:0]  char_class,
  input  logic [15:0] cluster,
  input  logic        glyph_valid,
  input  logic        last_glyph,
  input  logic [15:0] text_length,
  output logic        result_valid,
  output logic [8:0]  line_start,
  output logic [15:0] line_end_char,
  output logic [23:0] line_width,
  output logic [23:0] trimmed_width,
  output logic [21:0] baseline_y,
  output logic        last_line,
  output logic [23:0] total_width,
  output logic [23:0] total_width_ws,
  output logic [21:0] total_height,
  output logic [6:0]  line_count
);

  glb_cmd_t  cmd;
  glb_stat_t stat;

  assign cfg_ready = 1'b1;

  glb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last_glyph(last_glyph),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  glb_dp #(.MAX_GLYPHS(MAX_GLYPHS), .MAX_LINE_OUT(MAX_LINE_OUT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .advance(advance), .char_class(char_class), .cluster(cluster),
    .glyph_valid(glyph_valid), .text_length(text_length),
    .result_valid(result_valid), .line_start(line_start),
    .line_end_char(line_end_char), .line_width(line_width),
    .trimmed_width(trimmed_width), .baseline_y(baseline_y), .last_line(last_line),
    .total_width(total_width), .total_width_ws(total_width_ws),
    .total_height(total_height), .line_count(line_count)
  );

endmodule
